FILE: hdl/pal_pkg.sv
package pal_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int LENGTH_WIDTH = 40;

  // coordinate difference magnitude and root share one width
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int REM_W  = DIFF_W + 2;
  localparam int STEP_W = REM_W + 2;
  localparam int CNT_W  = $clog2(DIFF_W);
  localparam int SUM_W  = ((LENGTH_WIDTH > DIFF_W) ? LENGTH_WIDTH : DIFF_W) + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LENGTH_WIDTH-1:0]       length_t;
  typedef logic [DIFF_W-1:0]             diff_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [REM_W-1:0]              rem_t;
  typedef logic [STEP_W-1:0]             step_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [SUM_W-1:0]              sum_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL_X = 6'b000010,
    ST_MUL_Y = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  // magnitude of the difference of two signed coordinates
  function automatic diff_t abs_diff(input coord_t a, input coord_t b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? diff_t'(-d) : diff_t'(d);
  endfunction

endpackage

FILE: hdl/polyline_arc_length.sv
// cumulative arc length along a polyline
//
// input channel: one point per transfer (x_coord_i, y_coord_i, signed, 8 fraction
// bits) with start_path_i marking the first point of a new polyline.
// output channel: one result per input transfer, arc_length_o (unsigned, 8
// fraction bits) and saturated_o, set when the total sits at its maximum.
//
// processing: a start point goes from the input transfer straight to the output
// register. any other point has its coordinate differences registered, then
// passes the single 25x25 multiplier (dx squared, then dy squared) and the sum
// of squares, the bit-serial square root at one root bit per cycle (25 bits),
// and the load of the output register. a new point is taken only once the
// previous result is in the output register.
//
// reset clears the previous point to (0, 0), the running length to 0 and
// empties the output register. when the receiver stalls the result waits in
// the output register while the next point is already taken and worked on;
// a finished result that finds the register full waits until it drains.
module polyline_arc_length (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pal_pkg::coord_t     x_coord_i,
  input  pal_pkg::coord_t     y_coord_i,
  input  logic                start_path_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output pal_pkg::length_t    arc_length_o,
  output logic                saturated_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  localparam pal_pkg::sum_t LMAX =
    pal_pkg::sum_t'({pal_pkg::LENGTH_WIDTH{1'b1}});

  pal_pkg::state_e  state_q, state_d;
  pal_pkg::coord_t  prev_x_q, prev_y_q;
  pal_pkg::length_t run_q;
  logic             start_q;
  pal_pkg::diff_t   dx_q, dy_q;
  pal_pkg::sq_t     prod_q, rad_q;
  pal_pkg::rem_t    rem_q;
  pal_pkg::diff_t   root_q;
  pal_pkg::cnt_t    cnt_q;
  logic             out_valid_q;
  pal_pkg::length_t arc_q;
  logic             sat_q;

  logic             in_xfer;
  logic             out_load;
  pal_pkg::diff_t   mul_a;
  pal_pkg::step_t   rem_sh, trial;
  logic             take;
  pal_pkg::rem_t    rem_nx;
  pal_pkg::sum_t    sum;
  pal_pkg::length_t total;

  assign in_ready_o = (state_q == pal_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // output register free or draining this cycle
  assign out_load   = (state_q == pal_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // shared multiplier: dx squared first, then dy squared
  assign mul_a = (state_q == pal_pkg::ST_MUL_X) ? dx_q : dy_q;

  // one root bit per cycle: bring down two radicand bits, try (root << 2) | 1
  assign rem_sh = {rem_q, rad_q[pal_pkg::SQ_W-1 -: 2]};
  assign trial  = pal_pkg::step_t'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);
  assign rem_nx = take ? pal_pkg::rem_t'(rem_sh - trial) : pal_pkg::rem_t'(rem_sh);

  // saturating accumulate
  assign sum   = pal_pkg::sum_t'(run_q) + pal_pkg::sum_t'(root_q);
  assign total = start_q ? '0
               : (sum > LMAX) ? pal_pkg::length_t'(LMAX)
               : sum[pal_pkg::LENGTH_WIDTH-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      pal_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = start_path_i ? pal_pkg::ST_DONE : pal_pkg::ST_MUL_X;
        end
      end
      pal_pkg::ST_MUL_X: state_d = pal_pkg::ST_MUL_Y;
      pal_pkg::ST_MUL_Y: state_d = pal_pkg::ST_ADD;
      pal_pkg::ST_ADD:   state_d = pal_pkg::ST_ROOT;
      pal_pkg::ST_ROOT: begin
        if (cnt_q == '0) begin
          state_d = pal_pkg::ST_DONE;
        end
      end
      pal_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = pal_pkg::ST_IDLE;
        end
      end
      default: state_d = pal_pkg::ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pal_pkg::ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        prev_x_q <= x_coord_i;
        prev_y_q <= y_coord_i;
      end
      if (out_load) begin
        run_q       <= total;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      start_q <= start_path_i;
      dx_q    <= pal_pkg::abs_diff(x_coord_i, prev_x_q);
      dy_q    <= pal_pkg::abs_diff(y_coord_i, prev_y_q);
      root_q  <= '0;
    end
    if (state_q == pal_pkg::ST_MUL_X || state_q == pal_pkg::ST_MUL_Y) begin
      prod_q <= pal_pkg::sq_t'(mul_a) * pal_pkg::sq_t'(mul_a);
    end
    if (state_q == pal_pkg::ST_MUL_Y) begin
      rad_q <= prod_q;
    end
    if (state_q == pal_pkg::ST_ADD) begin
      rad_q <= rad_q + prod_q;
      rem_q <= '0;
      cnt_q <= pal_pkg::cnt_t'(pal_pkg::DIFF_W - 1);
    end
    if (state_q == pal_pkg::ST_ROOT) begin
      rad_q  <= {rad_q[pal_pkg::SQ_W-3:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= {root_q[pal_pkg::DIFF_W-2:0], take};
      cnt_q  <= cnt_q - pal_pkg::cnt_t'(1);
    end
    if (out_load) begin
      arc_q <= total;
      sat_q <= (pal_pkg::sum_t'(total) == LMAX);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign arc_length_o = arc_q;
  assign saturated_o  = sat_q;

endmodule

FILE: hdl/pal_checker.sv
module pal_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input pal_pkg::coord_t  x_coord_i,
  input pal_pkg::coord_t  y_coord_i,
  input logic             start_path_i,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input pal_pkg::length_t arc_length_o,
  input logic             saturated_o,
  input logic             out_valid_o,
  input logic             out_ready_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(arc_length_o)
      && $stable(saturated_o))
    else $error("result changed while stalled");

  // flag agrees with the total
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (saturated_o == (&arc_length_o)))
    else $error("saturated flag disagrees with arc length");

  // one point at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready right after an input transfer");

  // no result appears in the cycle after a transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result too early");

  // a start point with the output register empty yields a zero length
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && start_path_i && !out_valid_o |=> ##1
      (out_valid_o && arc_length_o == '0 && !saturated_o))
    else $error("start point did not give zero");

endmodule

bind polyline_arc_length pal_checker u_pal_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  // extremes of a coordinate and of the running length
  localparam pal_pkg::coord_t  C_MAX   = {1'b0, {(pal_pkg::COORD_WIDTH-1){1'b1}}};
  localparam pal_pkg::coord_t  C_MIN   = {1'b1, {(pal_pkg::COORD_WIDTH-1){1'b0}}};
  localparam pal_pkg::length_t LEN_MAX = '1;

  localparam int RAND_ITEMS = 1850;
  localparam int TAIL_WAIT  = 40;

  typedef struct packed {
    pal_pkg::length_t len;
    logic             sat;
  } arc_result_t;

  // one row of the directed table: a point and a typed-in result where it is
  // obvious (typed = 0 leaves the check to the predictor)
  typedef struct packed {
    pal_pkg::coord_t  x;
    pal_pkg::coord_t  y;
    logic             sp;
    logic             typed;
    pal_pkg::length_t len;
    logic             sat;
  } point_row_t;

  localparam int NROWS = 15;
  localparam point_row_t DIRECTED [NROWS] = '{
    // no start after reset: distance measured from the origin, 3-4-5 triangle
    '{768,     1024,     1'b0, 1'b1, 1280,     1'b0},
    // same point again: zero distance
    '{768,     1024,     1'b0, 1'b1, 1280,     1'b0},
    // new polyline at the origin
    '{0,       0,        1'b1, 1'b1, 0,        1'b0},
    // root of two lsbs truncates to one
    '{1,       1,        1'b0, 1'b1, 1,        1'b0},
    '{2,       2,        1'b0, 1'b1, 2,        1'b0},
    // full-width horizontal span, then a half-span vertical step
    '{C_MIN,   0,        1'b1, 1'b1, 0,        1'b0},
    '{C_MAX,   0,        1'b0, 1'b1, 16777215, 1'b0},
    '{C_MAX,   C_MIN,    1'b0, 1'b1, 25165823, 1'b0},
    // full diagonal
    '{C_MIN,   C_MAX,    1'b0, 1'b0, 0,        1'b0},
    // all ones, then back to the origin
    '{-1,      -1,       1'b1, 1'b1, 0,        1'b0},
    '{0,       0,        1'b0, 1'b1, 1,        1'b0},
    '{300,     -400,     1'b0, 1'b1, 501,      1'b0},
    // alternating bit patterns
    '{24'h555555, 24'hAAAAAA, 1'b0, 1'b0, 0,   1'b0},
    // restart away from the origin, then stay put
    '{1280,    0,        1'b1, 1'b1, 0,        1'b0},
    '{1280,    0,        1'b0, 1'b1, 0,        1'b0}
  };

  logic             clk_i;
  logic             rst_ni       = 1'b0;
  pal_pkg::coord_t  x_coord_i    = '0;
  pal_pkg::coord_t  y_coord_i    = '0;
  logic             start_path_i = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  pal_pkg::length_t arc_length_o;
  logic             saturated_o;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;

  // predictor state: last point seen and the running length
  pal_pkg::coord_t  last_x  = '0;
  pal_pkg::coord_t  last_y  = '0;
  pal_pkg::length_t run_len = '0;

  arc_result_t pending_arcs [$];
  int          err_cnt  = 0;
  bit          no_idle  = 1'b0;
  int          hold_cnt = 0;

  polyline_arc_length u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .start_path_i (start_path_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .arc_length_o (arc_length_o),
    .saturated_o  (saturated_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // magnitude of a coordinate difference, one bit wider than a coordinate
  function automatic pal_pkg::diff_t coord_gap(pal_pkg::coord_t a, pal_pkg::coord_t b);
    logic [pal_pkg::DIFF_W-1:0] d;
    d = {a[pal_pkg::COORD_WIDTH-1], a} - {b[pal_pkg::COORD_WIDTH-1], b};
    return d[pal_pkg::DIFF_W-1] ? pal_pkg::diff_t'(-d) : d;
  endfunction

  // exact floor of the square root, one result bit per pass from the top
  function automatic pal_pkg::diff_t floor_root(logic [pal_pkg::SQ_W:0] s);
    pal_pkg::diff_t         r;
    pal_pkg::diff_t         c;
    logic [pal_pkg::SQ_W:0] cc;
    r = '0;
    for (int b = pal_pkg::DIFF_W - 1; b >= 0; b--) begin
      c  = r | (pal_pkg::diff_t'(1) << b);
      cc = (pal_pkg::SQ_W+1)'(c);
      if (cc * cc <= s) r = c;
    end
    return r;
  endfunction

  // cumulative length after this point; also moves the predictor state on
  function automatic arc_result_t next_arc_length(pal_pkg::coord_t x, pal_pkg::coord_t y,
                                                  logic sp);
    pal_pkg::diff_t         dx;
    pal_pkg::diff_t         dy;
    pal_pkg::diff_t         hop;
    logic [pal_pkg::SQ_W:0] sq_sum;
    arc_result_t            r;
    if (sp) begin
      r.len = '0;
    end else begin
      dx     = coord_gap(x, last_x);
      dy     = coord_gap(y, last_y);
      sq_sum = (pal_pkg::SQ_W+1)'(dx) * (pal_pkg::SQ_W+1)'(dx)
             + (pal_pkg::SQ_W+1)'(dy) * (pal_pkg::SQ_W+1)'(dy);
      hop    = floor_root(sq_sum);
      // clamp rather than wrap once the total would pass the maximum
      if (pal_pkg::length_t'(hop) > LEN_MAX - run_len) r.len = LEN_MAX;
      else r.len = run_len + pal_pkg::length_t'(hop);
    end
    r.sat   = (r.len == LEN_MAX);
    last_x  = x;
    last_y  = y;
    run_len = r.len;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small random step around a coordinate, wrapping at the field width
  function automatic pal_pkg::coord_t nudge(pal_pkg::coord_t c);
    int unsigned span;
    int unsigned mag;
    span = 32'd1 << $urandom_range(0, 14);
    mag  = $urandom_range(0, span);
    return $urandom_range(0, 1) ? c + pal_pkg::coord_t'(mag) : c - pal_pkg::coord_t'(mag);
  endfunction

  function automatic pal_pkg::coord_t corner_value();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // one input transfer; the expectation is queued at the accepting edge
  task automatic send_point(pal_pkg::coord_t x, pal_pkg::coord_t y, logic sp, logic typed,
                            arc_result_t typed_res);
    int          gap;
    arc_result_t model_res;
    arc_result_t exp_res;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_coord_i    <= x;
    y_coord_i    <= y;
    start_path_i <= sp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // the predictor runs for every point so its state tracks the block
    model_res    = next_arc_length(x, y, sp);
    exp_res      = typed ? typed_res : model_res;
    pending_arcs = {pending_arcs, exp_res};
  endtask

  // receiver back-pressure: ready held low for a random stretch now and then
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_idle) hold_cnt <= pick_gap();
    end
  end

  // compare each result transfer with the oldest outstanding expectation
  always @(posedge clk_i) begin
    arc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_arcs.size() == 0) begin
        $error("unexpected result: arc_length %0d saturated %0b", arc_length_o,
               saturated_o);
        err_cnt++;
      end else begin
        want = pending_arcs.pop_front();
        if (arc_length_o !== want.len) begin
          $error("arc_length: expected %0d, got %0d", want.len, arc_length_o);
          err_cnt++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    point_row_t      row;
    arc_result_t     typed_res;
    pal_pkg::coord_t px;
    pal_pkg::coord_t py;
    logic            psp;
    int              mode;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NROWS; i++) begin
      row           = DIRECTED[i];
      typed_res.len = row.len;
      typed_res.sat = row.sat;
      send_point(row.x, row.y, row.sp, row.typed, typed_res);
    end

    // random polylines: mostly short hops along a path, with jumps,
    // corners and restarts mixed in; idling switched off in some stretches
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      psp  = ($urandom_range(0, 9) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 45) begin
        px = nudge(last_x);
        py = nudge(last_y);
      end else if (mode < 80) begin
        px = pal_pkg::coord_t'($urandom);
        py = pal_pkg::coord_t'($urandom);
      end else if (mode < 92) begin
        px = corner_value();
        py = corner_value();
      end else begin
        px = last_x;
        py = $urandom_range(0, 1) ? last_y : nudge(last_y);
      end
      send_point(px, py, psp, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then give stray transfers a chance to show
    while (pending_arcs.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[polyline_arc_length] OK");
    end else begin
      $display("[polyline_arc_length] ERROR");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run with the longest idles and stalls
  initial begin
    #20_000_000;
    $display("[polyline_arc_length] ERROR");
    $finish;
  end

endmodule
